>>> design/frps_pkg.sv
// Package for the flashing ratchet particle step block.
// Holds register indexes, the config bundle and per-item flags; no dependencies.
package frps_pkg;

  localparam int MAX_PARTICLES_DEF = 4096;
  localparam int POSITION_BITS_DEF = 32;
  localparam int SUM_BITS          = 44;
  localparam int PIPE_STAGES       = 10;
  localparam int CFG_INDEX_BITS    = 4;
  localparam int CFG_DATA_BITS     = 24;
  localparam int INDEX_OUT_BITS    = 12;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PARTICLE_COUNT    = 4'd0,
    REG_STEPS_PER_PERIOD  = 4'd1,
    REG_OFF_STEPS         = 4'd2,
    REG_TOTAL_STEPS       = 4'd3,
    REG_DIFFUSION_SCALE   = 4'd4,
    REG_INV_SPATIAL       = 4'd5,
    REG_DRIFT_GAIN        = 4'd6,
    REG_TWICE_ASYMMETRY   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [12:0]        particle_count;
    logic [15:0]        steps_per_period;
    logic [15:0]        off_steps;
    logic [23:0]        total_steps;
    logic [15:0]        diffusion_scale;
    logic [19:0]        inverse_spatial_period;
    logic signed [23:0] drift_gain;
    logic [15:0]        twice_asymmetry;
  } cfg_t;

  typedef struct packed {
    logic on;
    logic last_step;
    logic done;
  } meta_t;

endpackage

>>> design/frps_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module frps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> design/frps_ctrl.sv
// Control: config registers, particle/phase/step counters, hazard interlock and
// the post-reset clearing pass over the position memory. Uses frps_pkg.
module frps_ctrl #(
  parameter int MAX_PARTICLES = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [frps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [frps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  sample_valid,
  input  logic                                  adv,
  input  logic [frps_pkg::PIPE_STAGES-1:0]      stage_vld,
  input  logic [frps_pkg::PIPE_STAGES-1:0][$clog2(MAX_PARTICLES)-1:0] stage_idx,
  output logic                                  accept,
  output logic                                  sample_stall,
  output logic [$clog2(MAX_PARTICLES)-1:0]      rd_idx,
  output frps_pkg::meta_t                       meta,
  output frps_pkg::cfg_t                        cfg,
  output logic                                  clearing,
  output logic [$clog2(MAX_PARTICLES)-1:0]      clr_addr
);
  import frps_pkg::*;

  localparam int IW  = $clog2(MAX_PARTICLES);
  localparam int CNW = (IW + 1 > 13) ? IW + 1 : 13;
  localparam logic [CNW-1:0] MAXC = CNW'(MAX_PARTICLES);

  logic [IW-1:0]  particle_counter;
  logic [15:0]    phase;
  logic [23:0]    step;
  logic [IW:0]    clr_ptr;

  logic [CNW-1:0] cnt, cnt_lim;
  logic [IW-1:0]  last_idx;
  logic           last_particle, last_step, hazard;
  logic [15:0]    period;
  logic [23:0]    total;
  logic [16:0]    phase_inc;
  logic [24:0]    step_inc;

  assign cfg_ready = 1'b1;
  assign clearing  = (clr_ptr != (IW+1)'(MAX_PARTICLES));
  assign clr_addr  = clr_ptr[IW-1:0];

  always_comb begin
    cnt      = (cfg.particle_count == '0) ? CNW'(1) : CNW'(cfg.particle_count);
    cnt_lim  = (cnt > MAXC) ? MAXC : cnt;
    last_idx = IW'(cnt_lim - CNW'(1));
    last_particle = (particle_counter >= last_idx);
    rd_idx   = last_particle ? last_idx : particle_counter;
    period   = (cfg.steps_per_period == '0) ? 16'd1 : cfg.steps_per_period;
    total    = (cfg.total_steps == '0) ? 24'd1 : cfg.total_steps;
    phase_inc = {1'b0, phase} + 17'd1;
    step_inc  = {1'b0, step} + 25'd1;
    last_step = (step_inc >= {1'b0, total});
    meta.on        = (phase > cfg.off_steps);
    meta.last_step = last_step;
    meta.done      = last_step && last_particle;
    hazard = 1'b0;
    for (int k = 0; k < PIPE_STAGES; k++) begin
      if (stage_vld[k] && stage_idx[k] == rd_idx) begin
        hazard = 1'b1;
      end
    end
  end

  assign sample_stall = !(adv && !hazard && !clearing);
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_counter <= '0;
      phase            <= '0;
      step             <= '0;
      clr_ptr          <= '0;
      cfg.particle_count         <= 13'd4096;
      cfg.steps_per_period       <= 16'd3000;
      cfg.off_steps              <= 16'd1667;
      cfg.total_steps            <= 24'd15000;
      cfg.diffusion_scale        <= 16'd829;
      cfg.inverse_spatial_period <= 20'd43691;
      cfg.drift_gain             <= -24'sd8785;
      cfg.twice_asymmetry        <= 16'd6554;
    end else begin
      if (clearing) begin
        clr_ptr <= clr_ptr + (IW+1)'(1);
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PARTICLE_COUNT:   cfg.particle_count         <= cfg_data[12:0];
          REG_STEPS_PER_PERIOD: cfg.steps_per_period       <= cfg_data[15:0];
          REG_OFF_STEPS:        cfg.off_steps              <= cfg_data[15:0];
          REG_TOTAL_STEPS:      cfg.total_steps            <= cfg_data[23:0];
          REG_DIFFUSION_SCALE:  cfg.diffusion_scale        <= cfg_data[15:0];
          REG_INV_SPATIAL:      cfg.inverse_spatial_period <= cfg_data[19:0];
          REG_DRIFT_GAIN:       cfg.drift_gain             <= signed'(cfg_data[23:0]);
          REG_TWICE_ASYMMETRY:  cfg.twice_asymmetry        <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (last_particle) begin
          particle_counter <= '0;
          if (meta.done) begin
            step  <= '0;
            phase <= '0;
          end else begin
            step  <= step_inc[23:0];
            phase <= (phase_inc >= {1'b0, period}) ? 16'd0 : phase_inc[15:0];
          end
        end else begin
          particle_counter <= rd_idx + IW'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept) else $error("item accepted during clearing pass");
`endif
endmodule

>>> design/frps_datapath.sv
// Update pipeline: noise scaling, saturating add, sine/cosine polynomial,
// drift, write-back data, sum accumulator and output register. Uses frps_pkg.
module frps_datapath #(
  parameter int MAX_PARTICLES = 4096,
  parameter int POSITION_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic [$clog2(MAX_PARTICLES)-1:0]     rd_idx,
  input  frps_pkg::meta_t                      meta,
  input  logic signed [15:0]                   noise_sample,
  input  frps_pkg::cfg_t                       cfg,
  input  logic [POSITION_BITS-1:0]             rdata,
  output logic                                 adv,
  output logic [frps_pkg::PIPE_STAGES-1:0]     stage_vld,
  output logic [frps_pkg::PIPE_STAGES-1:0][$clog2(MAX_PARTICLES)-1:0] stage_idx,
  output logic                                 wr_en,
  output logic [$clog2(MAX_PARTICLES)-1:0]     wr_idx,
  output logic [POSITION_BITS-1:0]             wr_data,
  input  logic                                 result_stall,
  output logic                                 result_valid,
  output logic [frps_pkg::INDEX_OUT_BITS-1:0]  particle_index,
  output logic signed [31:0]                   new_position,
  output logic                                 potential_on,
  output logic                                 run_done,
  output logic signed [frps_pkg::SUM_BITS-1:0] position_sum
);
  import frps_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int XW = ((PB > 21) ? PB : 21) + 1;
  localparam int FW = ((PB > 27) ? PB : 27) + 1;
  localparam int SW = ((PB > SUM_BITS) ? PB : SUM_BITS) + 1;
  localparam logic signed [XW-1:0] XMAX = {{(XW-PB+1){1'b0}}, {(PB-1){1'b1}}};
  localparam logic signed [FW-1:0] FMAX = {{(FW-PB+1){1'b0}}, {(PB-1){1'b1}}};
  localparam logic signed [SW-1:0] AMAX = {{(SW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam int NS = PIPE_STAGES;

  meta_t              meta_s [NS];
  // per-stage payload
  logic signed [32:0] nprod1;
  logic signed [PB-1:0] x2, x3, x4, x5, x6, x7, x8, x9, x10;
  logic [15:0]        u3;
  logic [1:0]         q4, q5, q6;
  logic [14:0]        z4, z5, z6, z24, z25;
  logic [15:0]        in5;
  logic [16:0]        mid6;
  logic signed [15:0] s7, s8;
  logic signed [15:0] cos8;
  logic signed [19:0] br9;
  logic signed [26:0] dr10;
  logic signed [SUM_BITS-1:0] acc;

  // combinational stage logic
  logic signed [32:0] nrnd;
  logic signed [XW-1:0] xs;
  logic signed [PB-1:0] xs_sat;
  logic [63:0]        x64;
  logic [51:0]        p3;
  logic [13:0]        r;
  logic [14:0]        zc;
  logic [29:0]        zz;
  logic [27:0]        t5;
  logic [30:0]        t6;
  logic [17:0]        mid_w;
  logic [31:0]        t7;
  logic [14:0]        smag;
  logic signed [31:0] ss;
  logic [16:0]        cos_w;
  logic signed [32:0] pa;
  logic signed [43:0] pg;
  logic signed [44:0] pgr;
  logic signed [FW-1:0] xf;
  logic signed [PB-1:0] xf_sat;
  logic signed [SW-1:0] as;
  logic signed [SUM_BITS-1:0] as_sat;

  assign adv = !result_valid || !result_stall;

  always_comb begin
    nrnd   = (nprod1 + 33'sd2048) >>> 12;
    xs     = XW'(signed'(rdata)) + XW'(nrnd);
    if (xs > XMAX)       xs_sat = PB'(XMAX);
    else if (xs < ~XMAX) xs_sat = PB'(~XMAX);
    else                 xs_sat = PB'(xs);

    x64 = 64'(x2);
    p3  = 52'(x64[31:0]) * 52'(cfg.inverse_spatial_period);

    r   = u3[13:0];
    zc  = u3[14] ? 15'(15'd16384 - {1'b0, r}) : {1'b0, r};
    zz  = 30'(zc) * 30'(zc);

    t5  = 28'(13'd4639) * 28'(z24);
    t6  = 31'(in5) * 31'(z25);
    mid_w = 18'd102944 - 18'(t6[30:14]);
    t7  = 32'(z6) * 32'(mid6);
    smag = t7[30:16];

    ss    = 32'(s7) * 32'(s7);
    cos_w = 17'd16384 - {1'b0, ss[28:14], 1'b0};
    pa    = $signed({1'b0, cfg.twice_asymmetry}) * 33'(cos8);
    pg    = 44'(cfg.drift_gain) * 44'(br9);
    pgr   = (45'(pg) + 45'sd131072) >>> 18;

    // drift only applies while the potential is on
    xf = FW'(x10) - (meta_s[NS-1].on ? FW'(dr10) : FW'(0));
    if (xf > FMAX)       xf_sat = PB'(FMAX);
    else if (xf < ~FMAX) xf_sat = PB'(~FMAX);
    else                 xf_sat = PB'(xf);

    as = SW'(acc) + SW'(xf_sat);
    if (as > AMAX)       as_sat = SUM_BITS'(AMAX);
    else if (as < ~AMAX) as_sat = SUM_BITS'(~AMAX);
    else                 as_sat = SUM_BITS'(as);
  end

  assign wr_en   = adv && stage_vld[NS-1];
  assign wr_idx  = stage_idx[NS-1];
  assign wr_data = xf_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld    <= '0;
      result_valid <= 1'b0;
      acc          <= '0;
    end else if (adv) begin
      stage_vld    <= {stage_vld[NS-2:0], accept};
      result_valid <= stage_vld[NS-1];
      if (stage_vld[NS-1] && meta_s[NS-1].last_step) begin
        acc <= meta_s[NS-1].done ? '0 : as_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_idx[0] <= rd_idx;
      meta_s[0]    <= meta;
      for (int k = 1; k < NS; k++) begin
        stage_idx[k] <= stage_idx[k-1];
        meta_s[k]    <= meta_s[k-1];
      end
      nprod1 <= 33'(noise_sample) * $signed({1'b0, cfg.diffusion_scale});
      x2  <= xs_sat;
      x3  <= x2;   u3 <= p3[31:16];
      x4  <= x3;   q4 <= u3[15:14]; z4 <= zc; z24 <= zz[28:14];
      x5  <= x4;   q5 <= q4; z5 <= z4; z25 <= z24;
      in5 <= 16'(17'd42047 - 17'(t5[27:14]));
      x6  <= x5;   q6 <= q5; z6 <= z5; mid6 <= mid_w[16:0];
      x7  <= x6;
      s7  <= q6[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
      x8  <= x7;   s8 <= s7; cos8 <= cos_w[15:0];
      x9  <= x8;
      br9 <= 20'(pa >>> 14) - 20'(s8);
      x10 <= x9;   dr10 <= pgr[26:0];
      if (stage_vld[NS-1]) begin
        particle_index <= INDEX_OUT_BITS'(32'(stage_idx[NS-1]));
        new_position   <= 32'(xf_sat);
        potential_on   <= meta_s[NS-1].on;
        run_done       <= meta_s[NS-1].done;
        position_sum   <= meta_s[NS-1].done ? as_sat : '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_adjacent_idx: assert property (@(posedge clk) disable iff (rst)
    stage_vld[NS-1] && stage_vld[NS-2] |-> stage_idx[NS-1] != stage_idx[NS-2])
    else $error("same particle in flight twice");
  a_sum_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !run_done |-> position_sum == '0)
    else $error("sum reported without run end");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(stage_vld))
    else $error("pipeline moved while output stalled");
  a_write_only_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> result_valid)
    else $error("write-back without a result");
`endif
endmodule

>>> design/flashing_ratchet_particle_step.sv
// Top level of the flashing ratchet particle step block.
// Depends on frps_pkg, frps_ram, frps_ctrl and frps_datapath.
//
// Usage: each request on the sample channel (sample_valid/sample_stall) brings
// one noise sample for the next particle in order. The block reads the
// particle's position from a memory, adds the scaled noise, applies the ratchet
// drift when the potential is on, writes the position back and presents one
// result request on the result channel (result_valid/result_stall).
// Samples pass the pipeline stages and the output register to result_valid.
// Throughput: one sample per cycle when the result is not stalled; the limit
// is the single read-modify-write of the position memory, so an item whose
// particle is in the 10-stage pipeline waits (only with 10 or fewer particles).
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken at any
// time and must be made while the block is idle.
// Reset: counters and config return to their defaults, then a clearing pass
// zeroes all MAX_PARTICLES entries of the position memory; no sample is taken then.
// A stalled result holds its payload and the whole pipeline halts behind it.
module flashing_ratchet_particle_step #(
  parameter int MAX_PARTICLES = frps_pkg::MAX_PARTICLES_DEF,
  parameter int POSITION_BITS = frps_pkg::POSITION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [frps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [frps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [15:0]                   noise_sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [frps_pkg::INDEX_OUT_BITS-1:0]  particle_index,
  output logic signed [31:0]                   new_position,
  output logic                                 potential_on,
  output logic                                 run_done,
  output logic signed [frps_pkg::SUM_BITS-1:0] position_sum
);
  import frps_pkg::*;

  localparam int IW = $clog2(MAX_PARTICLES);

  cfg_t                  cfg;
  meta_t                 meta;
  logic                  accept, adv, clearing;
  logic [IW-1:0]         rd_idx, clr_addr, dp_wr_idx;
  logic [PIPE_STAGES-1:0]         stage_vld;
  logic [PIPE_STAGES-1:0][IW-1:0] stage_idx;
  logic                  dp_wr_en, ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [POSITION_BITS-1:0] dp_wr_data, ram_wdata, rdata;

  assign ram_we    = clearing || dp_wr_en;
  assign ram_waddr = clearing ? clr_addr : dp_wr_idx;
  assign ram_wdata = clearing ? '0 : dp_wr_data;

  frps_ram #(.WIDTH(POSITION_BITS), .DEPTH(MAX_PARTICLES)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(accept), .raddr(rd_idx), .rdata
  );

  frps_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .sample_valid, .adv, .stage_vld, .stage_idx, .accept, .sample_stall,
    .rd_idx, .meta, .cfg, .clearing, .clr_addr
  );

  frps_datapath #(.MAX_PARTICLES(MAX_PARTICLES), .POSITION_BITS(POSITION_BITS)) u_dp (
    .clk, .rst, .accept, .rd_idx, .meta, .noise_sample, .cfg, .rdata, .adv,
    .stage_vld, .stage_idx, .wr_en(dp_wr_en), .wr_idx(dp_wr_idx),
    .wr_data(dp_wr_data), .result_stall, .result_valid, .particle_index,
    .new_position, .potential_on, .run_done, .position_sum
  );

`ifndef SYNTHESIS
  a_clear_no_pipe: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !dp_wr_en) else $error("write-back during clearing pass");
`endif
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for flashing_ratchet_particle_step.
// Depends on frps_pkg and the block; predicts every particle update in SV and
// checks each result request while both channels idle and stall at random.
module tb;
  import frps_pkg::*;

  localparam int NPART = 4096;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 30;
  localparam int LONG_HOLD = 400;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 4'd12;

  typedef struct {
    logic [11:0]         idx;
    logic signed [31:0]  pos;
    logic                on;
    logic                done;
    logic signed [43:0]  sum;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [15:0] noise_sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [11:0] particle_index;
  logic signed [31:0] new_position;
  logic potential_on, run_done;
  logic signed [43:0] position_sum;

  flashing_ratchet_particle_step u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .noise_sample(noise_sample),
    .result_valid(result_valid), .result_stall(result_stall),
    .particle_index(particle_index), .new_position(new_position),
    .potential_on(potential_on), .run_done(run_done), .position_sum(position_sum)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state and config mirror
  longint positions_m [NPART];
  longint part_cnt, phase_cnt, step_cnt, sum_acc;
  cfg_t cfg_m;

  logic signed [15:0] noise_q [$];
  update_t updates_q [$];
  int errors = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int runs_done = 0;
  int on_seen = 0;
  longint cycles = 0;

  function automatic longint sat_to(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void advance_particle(input logic signed [15:0] nz);
    longint count, period, total, idx, x, prod, r, z, z2, inner, mid, s, cos2;
    longint bracket, drift;
    logic [15:0] u;
    logic [1:0] quad;
    logic last_p, last_s, on, done;
    update_t e;
    count = (cfg_m.particle_count == 0) ? 1 : cfg_m.particle_count;
    if (count > NPART) count = NPART;
    period = (cfg_m.steps_per_period == 0) ? 1 : cfg_m.steps_per_period;
    total = (cfg_m.total_steps == 0) ? 1 : cfg_m.total_steps;
    idx = (part_cnt >= count) ? count - 1 : part_cnt;
    last_p = (idx + 1 >= count);
    last_s = (step_cnt + 1 >= total);
    on = (phase_cnt > cfg_m.off_steps);
    x = positions_m[idx] + ((longint'(nz) * longint'(cfg_m.diffusion_scale) + 2048) >>> 12);
    x = sat_to(x, 32);
    if (on) begin
      prod = x * longint'(cfg_m.inverse_spatial_period);
      u = prod[31:16];
      quad = u[15:14];
      r = u[13:0];
      z = quad[0] ? 16384 - r : r;
      z2 = (z * z) >>> 14;
      inner = 42047 - ((4639 * z2) >>> 14);
      mid = 102944 - ((inner * z2) >>> 14);
      s = (z * mid) >>> 16;
      if (quad[1]) s = -s;
      cos2 = 16384 - 2 * ((s * s) >>> 14);
      bracket = ((longint'(cfg_m.twice_asymmetry) * cos2) >>> 14) - s;
      drift = (longint'(cfg_m.drift_gain) * bracket + (longint'(1) <<< 17)) >>> 18;
      x = sat_to(x - drift, 32);
    end
    positions_m[idx] = x;
    if (last_s) sum_acc = sat_to(sum_acc + x, 44);
    done = last_s && last_p;
    e.idx = idx[11:0];
    e.pos = x[31:0];
    e.on = on;
    e.done = done;
    e.sum = done ? sum_acc[43:0] : '0;
    if (last_p) begin
      part_cnt = 0;
      if (done) begin
        step_cnt = 0;
        phase_cnt = 0;
        sum_acc = 0;
      end else begin
        step_cnt++;
        phase_cnt = (phase_cnt + 1 >= period) ? 0 : phase_cnt + 1;
      end
    end else begin
      part_cnt = idx + 1;
    end
    updates_q.push_back(e);
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample driver
  int send_gap = 0;
  logic sample_taken = 1'b0;
  logic calm_send = 1'b0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (sample_valid && !sample_stall) begin
      advance_particle(noise_sample);
      samples_sent++;
      sample_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!sample_valid || sample_taken)) begin
      sample_taken = 1'b0;
      if ($urandom_range(0, 199) == 0) calm_send = ~calm_send;
      if (send_gap > 0) begin
        send_gap--;
        sample_valid <= 1'b0;
      end else if (noise_q.size() > 0) begin
        sample_valid <= 1'b1;
        noise_sample <= noise_q.pop_front();
        send_gap = calm_send ? 0 : pick_gap();
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // result receiver and checker
  int hold_cnt = 0;
  logic held_long = 1'b0;
  logic calm_recv = 1'b0;

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) calm_recv = ~calm_recv;
    if (!held_long && results_seen >= 120) begin
      held_long = 1'b1;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_stall <= 1'b1;
    end else if (calm_recv) begin
      result_stall <= 1'b0;
    end else begin
      hold_cnt = pick_gap();
      result_stall <= (hold_cnt > 0);
      if (hold_cnt > 0) hold_cnt--;
    end
  end

  always @(posedge clk) begin
    update_t e;
    if (result_valid && !result_stall) begin
      results_seen++;
      if (updates_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: idx %0d pos %0d", particle_index,
                                   new_position);
      end else begin
        e = updates_q.pop_front();
        if (potential_on) on_seen++;
        if (run_done) runs_done++;
        if (particle_index !== e.idx || new_position !== e.pos || potential_on !== e.on ||
            run_done !== e.done || position_sum !== e.sum) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: idx %0d/%0d pos %0d/%0d on %0b/%0b done %0b/%0b sum %0d/%0d",
                     e.idx, particle_index, e.pos, new_position, e.on, potential_on,
                     e.done, run_done, e.sum, position_sum);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] ix, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ix)
      REG_PARTICLE_COUNT:   cfg_m.particle_count = val[12:0];
      REG_STEPS_PER_PERIOD: cfg_m.steps_per_period = val[15:0];
      REG_OFF_STEPS:        cfg_m.off_steps = val[15:0];
      REG_TOTAL_STEPS:      cfg_m.total_steps = val[23:0];
      REG_DIFFUSION_SCALE:  cfg_m.diffusion_scale = val[15:0];
      REG_INV_SPATIAL:      cfg_m.inverse_spatial_period = val[19:0];
      REG_DRIFT_GAIN:       cfg_m.drift_gain = val[23:0];
      REG_TWICE_ASYMMETRY:  cfg_m.twice_asymmetry = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(input logic [12:0] cnt, input logic [15:0] per, input logic [15:0] off,
                         input logic [23:0] tot, input logic [15:0] dif, input logic [19:0] inv,
                         input logic [23:0] gain, input logic [15:0] asym);
    write_reg(REG_PARTICLE_COUNT, 24'(cnt));
    write_reg(REG_STEPS_PER_PERIOD, 24'(per));
    write_reg(REG_OFF_STEPS, 24'(off));
    write_reg(REG_TOTAL_STEPS, tot);
    write_reg(REG_DIFFUSION_SCALE, 24'(dif));
    write_reg(REG_INV_SPATIAL, 24'(inv));
    write_reg(REG_DRIFT_GAIN, gain);
    write_reg(REG_TWICE_ASYMMETRY, 24'(asym));
  endtask

  // checked at the rising edge so a request just queued at the falling edge is seen
  task automatic drain();
    do @(posedge clk);
    while (noise_q.size() != 0 || sample_valid || updates_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [12:0] cnt;
    int n;
    for (int i = 0; i < NPART; i++) positions_m[i] = 0;
    part_cnt = 0; phase_cnt = 0; step_cnt = 0; sum_acc = 0;
    cfg_m.particle_count = 4096;
    cfg_m.steps_per_period = 3000;
    cfg_m.off_steps = 1667;
    cfg_m.total_steps = 15000;
    cfg_m.diffusion_scale = 829;
    cfg_m.inverse_spatial_period = 43691;
    cfg_m.drift_gain = -24'sd8785;
    cfg_m.twice_asymmetry = 6554;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // a few requests at reset defaults, then directed extremes
    for (int i = 0; i < 4; i++) noise_q.push_back(16'($urandom));
    drain();
    write_reg(REG_UNUSED, 24'hFFFFFF);
    set_all(13'd3, 16'd2, 16'd0, 24'd2, 16'hFFFF, 20'hFFFFF, 24'h7FFFFF, 16'hFFFF);
    noise_q.push_back(16'sh7FFF); noise_q.push_back(-16'sh8000); noise_q.push_back(16'sh0000);
    noise_q.push_back(-16'sh0001); noise_q.push_back(16'sh0001); noise_q.push_back(16'sh5555);
    noise_q.push_back(-16'sh5556); noise_q.push_back(16'sh7FFF); noise_q.push_back(16'sh7FFF);
    noise_q.push_back(-16'sh8000); noise_q.push_back(16'sh2AAA); noise_q.push_back(16'sh0800);
    drain();
    // zero limits act as one, gain at its negative extreme
    set_all(13'd0, 16'd0, 16'hFFFF, 24'd0, 16'd0, 20'd0, 24'h800000, 16'd0);
    for (int i = 0; i < 6; i++) noise_q.push_back(16'($urandom));
    drain();
    // oversized count, then lowered below the counter
    set_all(13'h1FFF, 16'hFFFF, 16'd0, 24'hFFFFFF, 16'd40000, 20'd43691, 24'hFFDDAF, 16'd6554);
    for (int i = 0; i < 30; i++) noise_q.push_back(16'($urandom));
    drain();
    write_reg(REG_PARTICLE_COUNT, 24'd5);
    for (int i = 0; i < 12; i++) noise_q.push_back(16'($urandom));
    drain();

    // random phases
    while (samples_sent < 700) begin
      case ($urandom_range(0, 5))
        0: cnt = 13'd1;
        1: cnt = 13'($urandom_range(11, 40));
        default: cnt = 13'($urandom_range(2, 10));
      endcase
      set_all(cnt, 16'($urandom_range(0, 5)),
              ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4)),
              24'($urandom_range(0, 6)), 16'($urandom), 20'($urandom), 24'($urandom),
              16'($urandom));
      n = $urandom_range(20, 80);
      for (int i = 0; i < n; i++) noise_q.push_back(16'($urandom));
      drain();
    end

    $display("%0d samples checked against %0d results; %0d with potential on, %0d run ends",
             samples_sent, results_seen, on_seen, runs_done);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
